>>> rtl/ssoff_pkg.sv
// Shared constants for the shape spawn offset block: register indexes, shape codes,
// hash constants, pipeline depths and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package ssoff_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   // shape codes
   localparam int         KIND_W      = 3;
   localparam logic [2:0] KIND_POINT  = 3'd0;
   localparam logic [2:0] KIND_SPHERE = 3'd1;
   localparam logic [2:0] KIND_HEMI   = 3'd2;
   localparam logic [2:0] KIND_CONE   = 3'd3;
   localparam logic [2:0] KIND_BOX    = 3'd4;
   localparam logic [2:0] KIND_DISC   = 3'd5;
   localparam logic [2:0] KIND_LINE   = 3'd6;
   localparam logic [2:0] KIND_NONE   = 3'd7;

   // register indexes
   localparam int         CSR_INDEX_W    = 1;
   localparam logic [0:0] CSR_SHAPE_KIND = 1'b0;
   localparam logic [0:0] CSR_EXTENT     = 1'b1;

   // integer hash
   localparam int          HASH_SHIFT  = 13;
   localparam logic [31:0] HASH_MUL    = 32'd15731;
   localparam logic [31:0] HASH_ADD_LO = 32'd789221;
   localparam logic [31:0] HASH_ADD_HI = 32'd1376312589;
   localparam int          HASH_STAGES = 4;

   // iterative units: two prep stages, then one digit or rotation per stage
   localparam int PREP_STAGES  = 2;
   localparam int STEP_STAGES  = 32;
   localparam int UNIT_STAGES  = PREP_STAGES + STEP_STAGES;
   localparam int SQRT_STEPS   = 32;
   localparam int CBRT_STEPS   = 21;
   localparam int CORDIC_STEPS = 30;
   localparam int TAIL_STAGES  = 4;
   localparam int PIPE_STAGES  = HASH_STAGES + UNIT_STAGES + TAIL_STAGES;

   localparam logic [32:0] CORDIC_GAIN = 33'd652032874;
   localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;

   function automatic logic [32:0] atan_q30(input int idx);
      logic [32:0] val;
      case (idx)
         0:  val = 33'd843314856;
         1:  val = 33'd497837829;
         2:  val = 33'd263043836;
         3:  val = 33'd133525158;
         4:  val = 33'd67021686;
         5:  val = 33'd33543515;
         6:  val = 33'd16775850;
         7:  val = 33'd8388437;
         8:  val = 33'd4194282;
         9:  val = 33'd2097149;
         10: val = 33'd1048575;
         11: val = 33'd524287;
         12: val = 33'd262143;
         13: val = 33'd131071;
         14: val = 33'd65535;
         15: val = 33'd32767;
         16: val = 33'd16383;
         17: val = 33'd8191;
         18: val = 33'd4095;
         19: val = 33'd2047;
         20: val = 33'd1023;
         21: val = 33'd511;
         22: val = 33'd255;
         23: val = 33'd127;
         24: val = 33'd63;
         25: val = 33'd31;
         26: val = 33'd15;
         27: val = 33'd8;
         28: val = 33'd4;
         29: val = 33'd2;
         default: val = 33'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> rtl/ssoff_hash.sv
// Four-stage shift-xor-polynomial integer hash of one 32-bit seed to a 31-bit fraction.
// Uses ssoff_pkg for the hash constants.
`default_nettype none

module ssoff_hash (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] seed,
   output logic [30:0] frac
);

   logic [31:0] mix_ff, mix_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] poly_ff, poly_in;
   logic [31:0] mix_d1_ff, mix_d2_ff;
   logic [30:0] frac_ff, frac_in;
   logic [31:0] hash_sum;

   assign mix_in   = seed ^ (seed << ssoff_pkg::HASH_SHIFT);
   assign sq_in    = 32'(mix_ff * mix_ff);
   assign poly_in  = 32'(sq_ff * ssoff_pkg::HASH_MUL) + ssoff_pkg::HASH_ADD_LO;
   assign hash_sum = 32'(mix_d2_ff * poly_ff) + ssoff_pkg::HASH_ADD_HI;
   assign frac_in  = hash_sum[30:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mix_ff    <= mix_in;
         sq_ff     <= sq_in;
         mix_d1_ff <= mix_ff;
         poly_ff   <= poly_in;
         mix_d2_ff <= mix_d1_ff;
         frac_ff   <= frac_in;
      end
   end

   assign frac = frac_ff;

endmodule

`default_nettype wire

>>> rtl/ssoff_isqrt.sv
// Pipelined square root of 1 - u^2 in Q62: square, subtract, then one root bit per stage.
// Uses ssoff_pkg for the stage counts.
`default_nettype none

module ssoff_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] mag,
   output logic [31:0] root
);

   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam int          N       = ssoff_pkg::SQRT_STEPS;

   logic [63:0] sq_ff, sq_in;
   logic [63:0] rad_ff  [0:N];
   logic [35:0] rem_ff  [0:N];
   logic [31:0] root_ff [0:N];

   assign sq_in = 64'(mag) * 64'(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff      <= sq_in;
         rad_ff[0]  <= ONE_Q62 - sq_ff;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_digit
      logic [35:0] rem_sh, trial, rem_in;
      logic [31:0] root_in;
      logic        fit;

      assign rem_sh  = {rem_ff[j][33:0], rad_ff[j][63:62]};
      assign trial   = {2'b00, root_ff[j], 2'b01};
      assign fit     = rem_sh >= trial;
      assign rem_in  = fit ? rem_sh - trial : rem_sh;
      assign root_in = {root_ff[j][30:0], fit};

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[j+1]  <= {rad_ff[j][61:0], 2'b00};
            rem_ff[j+1]  <= rem_in;
            root_ff[j+1] <= root_in;
         end
      end
   end

   assign root = root_ff[N];

endmodule

`default_nettype wire

>>> rtl/ssoff_icbrt.sv
// Pipelined cube root of frac * 2^32: one root bit per stage, then delay to match the
// other units. Uses ssoff_pkg for the stage counts.
`default_nettype none

module ssoff_icbrt (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] frac,
   output logic [20:0] cube
);

   localparam int N   = ssoff_pkg::CBRT_STEPS;
   localparam int PAD = ssoff_pkg::STEP_STAGES - ssoff_pkg::CBRT_STEPS;

   logic [30:0] frac_d_ff;
   logic [62:0] rad_ff [0:N];
   logic [43:0] rem_ff [0:N];
   logic [20:0] y_ff   [0:N];
   logic [41:0] y2_ff  [0:N];
   logic [20:0] q_dl_ff [0:PAD-1];

   always_ff @(posedge clock) begin
      if (en) begin
         frac_d_ff <= frac;
         rad_ff[0] <= {frac_d_ff, 32'd0};
         rem_ff[0] <= '0;
         y_ff[0]   <= '0;
         y2_ff[0]  <= '0;
      end
   end

   // remainder tracks prefix - y^3; next digit costs 12y^2 + 6y + 1
   for (genvar j = 0; j < N; j++) begin : g_digit
      logic [46:0] rem_sh, y_e, y2_e, cost, rem_full;
      logic [43:0] rem_in;
      logic [20:0] y_in;
      logic [43:0] y2_sum;
      logic [41:0] y2_in;
      logic        fit;

      assign rem_sh   = {rem_ff[j], rad_ff[j][62:60]};
      assign y_e      = 47'(y_ff[j]);
      assign y2_e     = 47'(y2_ff[j]);
      assign cost     = (y2_e << 3) + (y2_e << 2) + (y_e << 2) + (y_e << 1) + 47'd1;
      assign fit      = rem_sh >= cost;
      assign rem_full = fit ? rem_sh - cost : rem_sh;
      assign rem_in   = rem_full[43:0];
      assign y_in     = {y_ff[j][19:0], fit};
      assign y2_sum   = (44'(y2_ff[j]) << 2) + (fit ? (44'(y_ff[j]) << 2) + 44'd1 : 44'd0);
      assign y2_in    = y2_sum[41:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[j+1] <= {rad_ff[j][59:0], 3'b000};
            rem_ff[j+1] <= rem_in;
            y_ff[j+1]   <= y_in;
            y2_ff[j+1]  <= y2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_dl_ff[0] <= y_ff[N];
         for (int k = 1; k < PAD; k++) begin
            q_dl_ff[k] <= q_dl_ff[k-1];
         end
      end
   end

   assign cube = q_dl_ff[PAD-1];

endmodule

`default_nettype wire

>>> rtl/ssoff_cordic.sv
// Pipelined CORDIC sine and cosine of a turn fraction: angle scale, one rotation per stage,
// quadrant mapping. Uses ssoff_pkg for the gain, the arctangent table and stage counts.
`default_nettype none

module ssoff_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic        [30:0] frac,
   output logic signed [32:0] cos_val,
   output logic signed [32:0] sin_val
);

   localparam int N = ssoff_pkg::CORDIC_STEPS;

   logic        [59:0] zp_ff, zp_in;
   logic        [1:0]  quad_p_ff;
   logic        [1:0]  quad_ff [0:N];
   logic signed [32:0] x_ff [0:N+2];
   logic signed [32:0] y_ff [0:N+2];
   logic signed [32:0] z_ff [0:N];

   assign zp_in = 60'(frac[28:0]) * 60'(ssoff_pkg::TWO_PI_Q28);

   always_ff @(posedge clock) begin
      if (en) begin
         zp_ff      <= zp_in;
         quad_p_ff  <= frac[30:29];
         quad_ff[0] <= quad_p_ff;
         z_ff[0]    <= $signed({2'b00, zp_ff[59:29]});
         x_ff[0]    <= $signed(ssoff_pkg::CORDIC_GAIN);
         y_ff[0]    <= '0;
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_rot
      logic signed [32:0] dx, dy, ang;
      logic               neg;

      assign dx  = y_ff[j] >>> j;
      assign dy  = x_ff[j] >>> j;
      assign ang = $signed(ssoff_pkg::atan_q30(j));
      assign neg = z_ff[j][32];

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j+1]    <= neg ? x_ff[j] + dx : x_ff[j] - dx;
            y_ff[j+1]    <= neg ? y_ff[j] - dy : y_ff[j] + dy;
            z_ff[j+1]    <= neg ? z_ff[j] + ang : z_ff[j] - ang;
            quad_ff[j+1] <= quad_ff[j];
         end
      end
   end

   // rotate the first-quadrant result into place
   always_ff @(posedge clock) begin
      if (en) begin
         unique case (quad_ff[N])
            2'd0: begin
               x_ff[N+1] <= x_ff[N];
               y_ff[N+1] <= y_ff[N];
            end
            2'd1: begin
               x_ff[N+1] <= -y_ff[N];
               y_ff[N+1] <= x_ff[N];
            end
            2'd2: begin
               x_ff[N+1] <= -x_ff[N];
               y_ff[N+1] <= -y_ff[N];
            end
            default: begin
               x_ff[N+1] <= y_ff[N];
               y_ff[N+1] <= -x_ff[N];
            end
         endcase
         x_ff[N+2] <= x_ff[N+1];
         y_ff[N+2] <= y_ff[N+1];
      end
   end

   assign cos_val = x_ff[N+2];
   assign sin_val = y_ff[N+2];

endmodule

`default_nettype wire

>>> rtl/shape_spawn_offset.sv
// Top level of the shape spawn offset pipeline: config registers, hashes, root and CORDIC
// units, scaling and saturation. Depends on ssoff_pkg, ssoff_hash, ssoff_isqrt,
// ssoff_icbrt and ssoff_cordic.
//
//   port group   direction  handshake            payload
//   req_*        in         req_valid/req_stall  req_particle_index (32 b)
//   rsp_*        out        rsp_valid/rsp_stall  rsp_offset_x/y/z (signed Q8.FRAC_BITS)
//   csr_*        in         csr_we               csr_index, csr_wdata
//
// One item per cycle while the output is not stalled. Order of the pipeline: the hash, the
// root and CORDIC units (all of equal depth), the scaling multiplies, an output register.
// Synchronous reset clears the config registers and all valid bits.
// A stalled output freezes the whole pipeline; req_stall follows in the same cycle.
`default_nettype none

module shape_spawn_offset #(
   parameter int FRAC_BITS = ssoff_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_particle_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [8+FRAC_BITS:0]          rsp_offset_x,
   output logic signed [8+FRAC_BITS:0]          rsp_offset_y,
   output logic signed [8+FRAC_BITS:0]          rsp_offset_z,
   input  logic                                 csr_we,
   input  logic [ssoff_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7+FRAC_BITS:0]                 csr_wdata
);

   localparam int EW  = 8 + FRAC_BITS;
   localparam int SW  = EW + 5;
   localparam int UL  = ssoff_pkg::UNIT_STAGES;
   localparam int VL  = ssoff_pkg::PIPE_STAGES - 1;
   localparam logic        [EW+20:0] RND21   = (EW+21)'(64'd1 << 20);
   localparam logic        [EW+31:0] RND31U  = (EW+32)'(64'd1 << 30);
   localparam logic signed [EW+32:0] RND31   = (EW+33)'(64'd1 << 30);
   localparam logic signed [EW+33:0] RND31W  = (EW+34)'(64'd1 << 30);
   localparam logic signed [EW+33:0] RND30W  = (EW+34)'(64'd1 << 29);
   localparam logic signed [SW-1:0]  SAT_LIM = SW'((64'd1 << EW) - 64'd1);

   // configuration
   logic [2:0]    kind_ff;
   logic [EW-1:0] extent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= ssoff_pkg::KIND_POINT;
         extent_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ssoff_pkg::CSR_SHAPE_KIND: kind_ff   <= csr_wdata[2:0];
            ssoff_pkg::CSR_EXTENT:     extent_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // flow control
   logic          adv;
   logic [VL-1:0] vld_ff;
   logic          rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VL-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VL-1];
      end
   end

   // hashes of index*3+1, +2, +3
   logic [31:0] base;
   logic [30:0] fa, fb, fc;

   assign base = req_particle_index + {req_particle_index[30:0], 1'b0};

   ssoff_hash u_hash_a (.clock(clock), .en(adv), .seed(base + 32'd1), .frac(fa));
   ssoff_hash u_hash_b (.clock(clock), .en(adv), .seed(base + 32'd2), .frac(fb));
   ssoff_hash u_hash_c (.clock(clock), .en(adv), .seed(base + 32'd3), .frac(fc));

   // 2f - 1 in Q31 is f with its top bit flipped
   logic [31:0] sa_now, sb_now, sc_now, mag_a;

   assign sa_now = {~fa[30], fa[29:0], 1'b0};
   assign sb_now = {~fb[30], fb[29:0], 1'b0};
   assign sc_now = {~fc[30], fc[29:0], 1'b0};
   assign mag_a  = sa_now[31] ? 32'd0 - sa_now : sa_now;

   logic        [31:0] w_root;
   logic        [20:0] q_cube;
   logic signed [32:0] cos_val, sin_val;

   ssoff_isqrt  u_isqrt  (.clock(clock), .en(adv), .mag(mag_a), .root(w_root));
   ssoff_icbrt  u_icbrt  (.clock(clock), .en(adv), .frac(fc), .cube(q_cube));
   ssoff_cordic u_cordic (.clock(clock), .en(adv), .frac(fb),
                          .cos_val(cos_val), .sin_val(sin_val));

   logic [31:0] sa_dl_ff [0:UL-1];
   logic [31:0] sb_dl_ff [0:UL-1];
   logic [31:0] sc_dl_ff [0:UL-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_dl_ff[0] <= sa_now;
         sb_dl_ff[0] <= sb_now;
         sc_dl_ff[0] <= sc_now;
         for (int k = 1; k < UL; k++) begin
            sa_dl_ff[k] <= sa_dl_ff[k-1];
            sb_dl_ff[k] <= sb_dl_ff[k-1];
            sc_dl_ff[k] <= sc_dl_ff[k-1];
         end
      end
   end

   // scale 1: sphere radius and box axes
   logic        [EW+20:0] mq_prod, mq_rnd;
   logic        [EW-1:0]  m_in, m_ff;
   logic signed [EW+32:0] ext_s, sa_s, sb_s, sc_s, bxp, byp, bzp;
   logic signed [EW+32:0] bx_rnd, by_rnd, bz_rnd;
   logic signed [EW+1:0]  bx_in, by_in, bz_in;
   logic signed [EW+1:0]  bx_m1_ff, by_m1_ff, bz_m1_ff;
   logic        [31:0]    w_ff, sa_m1_ff;
   logic signed [32:0]    cs_m1_ff, sn_m1_ff;

   assign mq_prod = (EW+21)'(extent_ff) * (EW+21)'(q_cube);
   assign mq_rnd  = mq_prod + RND21;
   assign m_in    = mq_rnd[EW+20:21];
   assign ext_s   = $signed((EW+33)'(extent_ff));
   assign sa_s    = (EW+33)'($signed(sa_dl_ff[UL-1]));
   assign sb_s    = (EW+33)'($signed(sb_dl_ff[UL-1]));
   assign sc_s    = (EW+33)'($signed(sc_dl_ff[UL-1]));
   assign bxp     = sa_s * ext_s;
   assign byp     = sb_s * ext_s;
   assign bzp     = sc_s * ext_s;
   assign bx_rnd  = bxp + RND31;
   assign by_rnd  = byp + RND31;
   assign bz_rnd  = bzp + RND31;
   assign bx_in   = bx_rnd[EW+32:31];
   assign by_in   = by_rnd[EW+32:31];
   assign bz_in   = bz_rnd[EW+32:31];

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff     <= m_in;
         w_ff     <= w_root;
         sa_m1_ff <= sa_dl_ff[UL-1];
         cs_m1_ff <= cos_val;
         sn_m1_ff <= sin_val;
         bx_m1_ff <= bx_in;
         by_m1_ff <= by_in;
         bz_m1_ff <= bz_in;
      end
   end

   // scale 2: ring radius and height
   logic        [EW+31:0] mw_prod, mw_rnd;
   logic        [EW-1:0]  h_in, h_ff;
   logic signed [32:0]    sa33, yu;
   logic signed [EW+33:0] my_prod, my_rnd;
   logic signed [EW+2:0]  oy_in, oy_m2_ff, oy_m3_ff;
   logic signed [32:0]    cs_m2_ff, sn_m2_ff;
   logic signed [EW+1:0]  bx_m2_ff, by_m2_ff, bz_m2_ff;

   assign mw_prod = (EW+32)'(m_ff) * (EW+32)'(w_ff);
   assign mw_rnd  = mw_prod + RND31U;
   assign h_in    = mw_rnd[EW+30:31];
   assign sa33    = 33'($signed(sa_m1_ff));
   assign yu      = (kind_ff == ssoff_pkg::KIND_HEMI && sa33[32]) ? -sa33 : sa33;
   assign my_prod = $signed((EW+34)'(m_ff)) * (EW+34)'(yu);
   assign my_rnd  = my_prod + RND31W;
   assign oy_in   = my_rnd[EW+33:31];

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff     <= h_in;
         oy_m2_ff <= oy_in;
         cs_m2_ff <= cs_m1_ff;
         sn_m2_ff <= sn_m1_ff;
         bx_m2_ff <= bx_m1_ff;
         by_m2_ff <= by_m1_ff;
         bz_m2_ff <= bz_m1_ff;
      end
   end

   // scale 3: project the ring onto x and z
   logic signed [EW+33:0] h_s, hc_prod, hs_prod, hc_rnd, hs_rnd;
   logic signed [EW+3:0]  ox_in, oz_in, ox_m3_ff, oz_m3_ff;
   logic signed [EW+1:0]  bx_m3_ff, by_m3_ff, bz_m3_ff;

   assign h_s     = $signed((EW+34)'(h_ff));
   assign hc_prod = h_s * (EW+34)'(cs_m2_ff);
   assign hs_prod = h_s * (EW+34)'(sn_m2_ff);
   assign hc_rnd  = hc_prod + RND30W;
   assign hs_rnd  = hs_prod + RND30W;
   assign ox_in   = hc_rnd[EW+33:30];
   assign oz_in   = hs_rnd[EW+33:30];

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_m3_ff <= ox_in;
         oz_m3_ff <= oz_in;
         oy_m3_ff <= oy_m2_ff;
         bx_m3_ff <= bx_m2_ff;
         by_m3_ff <= by_m2_ff;
         bz_m3_ff <= bz_m2_ff;
      end
   end

   // select by shape and saturate
   function automatic logic signed [EW:0] sat_out(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] lo;
      lo = -SAT_LIM;
      if (v > SAT_LIM) return (EW+1)'(SAT_LIM);
      if (v < lo) return (EW+1)'(lo);
      return v[EW:0];
   endfunction

   logic signed [SW-1:0] x_sel, y_sel, z_sel;
   logic signed [EW:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;

   always_comb begin
      x_sel = '0;
      y_sel = '0;
      z_sel = '0;
      if (extent_ff != '0) begin
         case (kind_ff) inside
            ssoff_pkg::KIND_SPHERE, ssoff_pkg::KIND_HEMI: begin
               x_sel = SW'(ox_m3_ff);
               y_sel = SW'(oy_m3_ff);
               z_sel = SW'(oz_m3_ff);
            end
            ssoff_pkg::KIND_BOX: begin
               x_sel = SW'(bx_m3_ff);
               y_sel = SW'(by_m3_ff);
               z_sel = SW'(bz_m3_ff);
            end
            ssoff_pkg::KIND_DISC: begin
               x_sel = SW'(bx_m3_ff);
               y_sel = SW'(by_m3_ff);
            end
            ssoff_pkg::KIND_LINE: begin
               x_sel = SW'(bx_m3_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff <= sat_out(x_sel);
         rsp_y_ff <= sat_out(y_sel);
         rsp_z_ff <= sat_out(z_sel);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_offset_x = rsp_x_ff;
   assign rsp_offset_y = rsp_y_ff;
   assign rsp_offset_z = rsp_z_ff;

endmodule

`default_nettype wire

>>> rtl/ssoff_checker.sv
// Port-level checks for shape_spawn_offset, bound to every instance of it.
// Depends on ssoff_pkg and shape_spawn_offset.
`default_nettype none

module ssoff_checker #(
   parameter int FRAC_BITS = ssoff_pkg::FRAC_BITS_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [8+FRAC_BITS:0]       rsp_offset_x,
   input logic signed [8+FRAC_BITS:0]       rsp_offset_y,
   input logic signed [8+FRAC_BITS:0]       rsp_offset_z
);

   localparam int EW = 8 + FRAC_BITS;
   localparam logic [EW:0] NEG_EDGE = {1'b1, {EW{1'b0}}};

   // saturation is symmetric: the most negative code never shows
   a_sat_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_offset_x != NEG_EDGE) && (rsp_offset_y != NEG_EDGE)
                    && (rsp_offset_z != NEG_EDGE))
      else $error("offset outside saturation range");

   // input backpressure only comes from a held transfer at the output
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_offset_x)
                                 && $stable(rsp_offset_y) && $stable(rsp_offset_z))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind shape_spawn_offset ssoff_checker #(.FRAC_BITS(FRAC_BITS)) u_ssoff_checker (.*);

`default_nettype wire
